@@ rtl/uera_pkg.sv @@
// ----------------------------------------------------------------------------
// uera_pkg
// Shared types and constants of the averaged ultrasonic echo ranger.
// ----------------------------------------------------------------------------
`default_nettype none

package uera_pkg;

   // Sensor and averaging geometry
   localparam int WINDOW     = 5;
   localparam int CHANNELS   = 3;

   // Fixed field widths
   localparam int CH_W       = 2;
   localparam int TRIG_W     = 3;
   localparam int ECHO_W     = 3;
   localparam int TIMEOUT_W  = 16;
   localparam int SCALE_W    = 16;
   localparam int TICK_W     = 17;
   localparam int LEN_W      = 16;
   localparam int DIST_W     = 15;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   // Trigger timing in ticks
   localparam int LOW_TICKS  = 5;
   localparam int HIGH_TICKS = 10;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = TIMEOUT_W'(26000);
   localparam logic [SCALE_W-1:0]   SCALE_Q16_RST    = SCALE_W'(2249);

   // Averaging window
   localparam int POS_W    = $clog2(WINDOW);
   localparam int SUM_W    = $clog2(WINDOW * ((1 << DIST_W) - 1) + 1);
   // Reciprocal of WINDOW, exact for every sum below 2**SUM_W
   localparam int RECIP_SH = SUM_W + $clog2(WINDOW);
   localparam int RECIP    = ((1 << RECIP_SH) + WINDOW - 1) / WINDOW;
   localparam int RECIP_W  = $clog2(RECIP + 1);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_TRIG_LOW,
      PH_TRIG_HIGH,
      PH_WAIT,
      PH_MEASURE
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_BAD_CHANNEL,
      ST_NO_ECHO,
      ST_ECHO_LONG
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ECHO_TIMEOUT,
      CSR_SCALE_Q16
   } csr_index_type;

   // Per-request result fields carried down the pipeline
   typedef struct packed {
      logic [TRIG_W-1:0] trig;
      logic              busy;
      logic              done;
      status_type        status;
      logic              ok;
      logic [CH_W-1:0]   ch;
   } res_type;

   // One new distance sample for the averaging window
   typedef struct packed {
      logic              wr_en;
      logic [CH_W-1:0]   ch;
      logic [DIST_W-1:0] distance;
   } sample_type;

endpackage

`default_nettype wire

@@ rtl/uera_window.sv @@
// ----------------------------------------------------------------------------
// uera_window
// Per-channel circular sample buffers with running sums.
// ----------------------------------------------------------------------------
`default_nettype none

module uera_window (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire uera_pkg::sample_type   sample,
   output logic [uera_pkg::SUM_W-1:0]  new_sum
);
   import uera_pkg::*;

   logic [DIST_W-1:0] store_ff [CHANNELS][WINDOW];
   logic [POS_W-1:0]  pos_ff   [CHANNELS];
   logic [SUM_W-1:0]  sum_ff   [CHANNELS];

   logic [POS_W-1:0]  pos_cur;
   logic [POS_W-1:0]  pos_in;

   assign pos_cur = pos_ff[sample.ch];
   assign pos_in  = (pos_cur == POS_W'(WINDOW - 1)) ? '0 : pos_cur + POS_W'(1);

   // Drop the oldest sample, add the new one
   assign new_sum = sum_ff[sample.ch] - SUM_W'(store_ff[sample.ch][pos_cur])
                    + SUM_W'(sample.distance);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            sum_ff[c] <= '0;
            for (int w = 0; w < WINDOW; w++) begin
               store_ff[c][w] <= '0;
            end
         end
      end else if (sample.wr_en) begin
         store_ff[sample.ch][pos_cur] <= sample.distance;
         pos_ff[sample.ch]            <= pos_in;
         sum_ff[sample.ch]            <= new_sum;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ultrasonic_echo_ranger_averaged.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_averaged
// Ranging sequencer for three echo sensors with a five-sample moving average.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  start_req, channel, echo_levels
// rsp_      out        rsp_valid/rsp_stall  trigger_levels, busy_res, done_res,
//                                           status, distance_cm
// csr_      in         csr_valid/csr_ready  index, wdata (always ready)
//
// One request per clock cycle sustained while rsp_stall stays low; each request
// is one sensor tick. A request passes from acceptance to the response through
// the input register, sequencer, scale multiply, window update, and
// divide-by-window multiply into the output register.
// Reset is synchronous; it restores the registers and clears all buffers.
// A stalled response holds the output; earlier stages keep filling until
// they are full, then req_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_echo_ranger_averaged (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_start_req,
   input  wire logic [uera_pkg::CH_W-1:0]      req_channel,
   input  wire logic [uera_pkg::ECHO_W-1:0]    req_echo_levels,

   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [uera_pkg::TRIG_W-1:0]         rsp_trigger_levels,
   output logic                                rsp_busy_res,
   output logic                                rsp_done_res,
   output logic [uera_pkg::STATUS_W-1:0]       rsp_status,
   output logic [uera_pkg::DIST_W-1:0]         rsp_distance_cm,

   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [uera_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [uera_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import uera_pkg::*;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [SCALE_W-1:0]   scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= ECHO_TIMEOUT_RST;
         scale_ff   <= SCALE_Q16_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ECHO_TIMEOUT: timeout_ff <= csr_wdata[TIMEOUT_W-1:0];
            CSR_SCALE_Q16:    scale_ff   <= csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipeline flow control: a stage moves on when the next one is empty
   // or moving on itself.
   // ---------------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic v0_in, v1_in, v2_in, v3_in, v4_in;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;
   logic take, fire0, fire1, fire2, fire3;

   assign rdy4  = !v4_ff || !rsp_stall;
   assign rdy3  = !v3_ff || rdy4;
   assign rdy2  = !v2_ff || rdy3;
   assign rdy1  = !v1_ff || rdy2;
   assign rdy0  = !v0_ff || rdy1;

   assign take  = req_valid && rdy0;
   assign fire0 = v0_ff && rdy1;
   assign fire1 = v1_ff && rdy2;
   assign fire2 = v2_ff && rdy3;
   assign fire3 = v3_ff && rdy4;

   assign req_stall = !rdy0;
   assign rsp_valid = v4_ff;

   assign v0_in = take  || (v0_ff && !rdy1);
   assign v1_in = fire0 || (v1_ff && !rdy2);
   assign v2_in = fire1 || (v2_ff && !rdy3);
   assign v3_in = fire2 || (v3_ff && !rdy4);
   assign v4_in = fire3 || (v4_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: input register
   // ---------------------------------------------------------------------
   logic              s0_start_ff;
   logic [CH_W-1:0]   s0_channel_ff;
   logic [ECHO_W-1:0] s0_echo_ff;

   always_ff @(posedge clock) begin
      if (take) begin
         s0_start_ff   <= req_start_req;
         s0_channel_ff <= req_channel;
         s0_echo_ff    <= req_echo_levels;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer: trigger low, trigger high, wait for echo, time the echo.
   // Advance only when a request moves from stage 0 to stage 1.
   // ---------------------------------------------------------------------
   phase_type          phase_ff, phase_in;
   logic [CH_W-1:0]    chan_ff, chan_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  tick_inc;
   logic [TICK_W-1:0]  timeout_ext;
   logic [(1 << CH_W)-1:0] echo_vec;
   logic               echo;
   logic               chan_ok;
   res_type            seq_res;

   assign tick_inc    = tick_ff + TICK_W'(1);
   assign timeout_ext = TICK_W'(timeout_ff);
   // Unused channel codes read as a silent echo
   assign echo_vec    = (1 << CH_W)'(s0_echo_ff);
   assign echo        = echo_vec[chan_ff];
   assign chan_ok     = s0_channel_ff < CH_W'(CHANNELS);

   // Next state
   always_comb begin
      phase_in = phase_ff;
      chan_in  = chan_ff;
      tick_in  = tick_ff;
      if (fire0) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (s0_start_ff && chan_ok) begin
                  chan_in  = s0_channel_ff;
                  phase_in = PH_TRIG_LOW;
                  tick_in  = TICK_W'(1);
               end
            end
            PH_TRIG_LOW: begin
               if (tick_ff >= TICK_W'(LOW_TICKS)) begin
                  phase_in = PH_TRIG_HIGH;
                  tick_in  = TICK_W'(1);
               end else begin
                  tick_in  = tick_inc;
               end
            end
            PH_TRIG_HIGH: begin
               if (tick_ff >= TICK_W'(HIGH_TICKS)) begin
                  phase_in = PH_WAIT;
                  tick_in  = '0;
               end else begin
                  tick_in  = tick_inc;
               end
            end
            PH_WAIT: begin
               if (echo) begin
                  phase_in = PH_MEASURE;
                  tick_in  = TICK_W'(1);
               end else if (tick_inc > timeout_ext) begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
               end else begin
                  tick_in  = tick_inc;
               end
            end
            PH_MEASURE: begin
               if (echo && (tick_inc <= timeout_ext)) begin
                  tick_in  = tick_inc;
               end else begin
                  phase_in = PH_IDLE;
                  tick_in  = '0;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               tick_in  = '0;
            end
         endcase
      end
   end

   // Outputs of this tick
   always_comb begin
      seq_res        = '0;
      seq_res.status = ST_OK;
      seq_res.ch     = chan_ff;
      seq_res.busy   = (phase_in != PH_IDLE);
      seq_res.trig   = (phase_in == PH_TRIG_HIGH) ? (TRIG_W'(1) << chan_in) : '0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (s0_start_ff && !chan_ok) begin
               seq_res.done   = 1'b1;
               seq_res.status = ST_BAD_CHANNEL;
            end
         end
         PH_WAIT: begin
            if (!echo && (tick_inc > timeout_ext)) begin
               seq_res.done   = 1'b1;
               seq_res.status = ST_NO_ECHO;
            end
         end
         PH_MEASURE: begin
            if (!echo) begin
               seq_res.done = 1'b1;
               seq_res.ok   = 1'b1;
            end else if (tick_inc > timeout_ext) begin
               seq_res.done   = 1'b1;
               seq_res.status = ST_ECHO_LONG;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         chan_ff  <= '0;
         tick_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         chan_ff  <= chan_in;
         tick_ff  <= tick_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: sequencer result and half pulse length
   // ---------------------------------------------------------------------
   res_type           s1_res_ff;
   logic [LEN_W-1:0]  s1_len_ff;

   always_ff @(posedge clock) begin
      if (fire0) begin
         s1_res_ff <= seq_res;
         s1_len_ff <= tick_ff[LEN_W:1];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: distance = (half length * scale) >> 16
   // ---------------------------------------------------------------------
   logic [LEN_W+SCALE_W-1:0] scale_prod;
   res_type                  s2_res_ff;
   logic [DIST_W-1:0]        s2_dist_ff;

   assign scale_prod = (LEN_W+SCALE_W)'(s1_len_ff) * (LEN_W+SCALE_W)'(scale_ff);

   always_ff @(posedge clock) begin
      if (fire1) begin
         s2_res_ff  <= s1_res_ff;
         s2_dist_ff <= scale_prod[SCALE_W +: DIST_W];
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: window update; only a good measurement enters the buffer
   // ---------------------------------------------------------------------
   sample_type         sample;
   logic [SUM_W-1:0]   new_sum;
   res_type            s3_res_ff;
   logic [SUM_W-1:0]   s3_sum_ff;

   assign sample.wr_en    = fire2 && s2_res_ff.ok;
   assign sample.ch       = s2_res_ff.ch;
   assign sample.distance = s2_dist_ff;

   uera_window u_window (
      .clock   (clock),
      .reset   (reset),
      .sample  (sample),
      .new_sum (new_sum)
   );

   always_ff @(posedge clock) begin
      if (fire2) begin
         s3_res_ff <= s2_res_ff;
         s3_sum_ff <= new_sum;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: output register; average = sum * recip >> shift
   // ---------------------------------------------------------------------
   logic [SUM_W+RECIP_W-1:0] avg_prod;
   logic [DIST_W-1:0]        avg;
   res_type                  s4_res_ff;
   logic [DIST_W-1:0]        s4_dist_ff;

   assign avg_prod = (SUM_W+RECIP_W)'(s3_sum_ff) * (SUM_W+RECIP_W)'(RECIP);
   assign avg      = avg_prod[RECIP_SH +: DIST_W];

   always_ff @(posedge clock) begin
      if (fire3) begin
         s4_res_ff  <= s3_res_ff;
         s4_dist_ff <= s3_res_ff.ok ? avg : '0;
      end
   end

   assign rsp_trigger_levels = s4_res_ff.trig;
   assign rsp_busy_res       = s4_res_ff.busy;
   assign rsp_done_res       = s4_res_ff.done;
   assign rsp_status         = s4_res_ff.status;
   assign rsp_distance_cm    = s4_dist_ff;

endmodule

`default_nettype wire

@@ sim/tb_ultrasonic_echo_ranger_averaged.sv @@
// ----------------------------------------------------------------------------
// tb_ultrasonic_echo_ranger_averaged
// Self-checking bench for the averaged three-sensor echo ranger.
//
// Each request is one sensor tick. A behavioral ranger inside the bench
// tracks the trigger sequence, echo wait, pulse count and the per-channel
// averaging windows, and queues the expected response of every accepted
// request. A checker compares every accepted response against the oldest
// queued one. Directed tests cover power-on settings, bad channels, starts
// while busy, timeout and scale limits and window wrap; a random part then
// runs measurement sequences under changing settings, sender gaps and
// response stalls.
// ----------------------------------------------------------------------------

module tb_ultrasonic_echo_ranger_averaged;
   timeunit 1ns;
   timeprecision 1ps;

   import uera_pkg::*;

   localparam int RANDOM_TICKS   = 460;
   localparam int SETTLE_CYCLES  = 8;     // pipeline is five deep, leave margin
   localparam int WATCHDOG_LIMIT = 1000;

   // One expected response
   typedef struct packed {
      logic [TRIG_W-1:0] trig;
      logic              busy;
      logic              done;
      status_type        status;
      logic [DIST_W-1:0] distance;
   } ranger_reading_type;

   // ------------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;

   logic                 req_valid;
   logic                 req_stall;
   logic                 req_start_req;
   logic [CH_W-1:0]      req_channel;
   logic [ECHO_W-1:0]    req_echo_levels;

   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [TRIG_W-1:0]    rsp_trigger_levels;
   logic                 rsp_busy_res;
   logic                 rsp_done_res;
   logic [STATUS_W-1:0]  rsp_status;
   logic [DIST_W-1:0]    rsp_distance_cm;

   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   always #2 clock = ~clock;

   ultrasonic_echo_ranger_averaged dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_start_req      (req_start_req),
      .req_channel        (req_channel),
      .req_echo_levels    (req_echo_levels),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_trigger_levels (rsp_trigger_levels),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .rsp_distance_cm    (rsp_distance_cm),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // ------------------------------------------------------------------------
   // Behavioral ranger: settings, sequencer state and averaging windows
   // ------------------------------------------------------------------------
   int unsigned cfg_timeout;
   int unsigned cfg_scale;

   phase_type       rng_phase;
   logic [CH_W-1:0] rng_channel;
   logic [TICK_W-1:0] rng_ticks;
   int unsigned     sample_ring [CHANNELS][WINDOW];
   int unsigned     ring_pos    [CHANNELS];
   int unsigned     ring_sum    [CHANNELS];

   ranger_reading_type pending_readings [$];

   // Bookkeeping
   int  mismatches;
   int  ticks_sent;
   int  readings_checked;
   int  finished_by_status [4];
   int  burst_left;
   bit  steady_sender;
   int  quiet_cycles;
   ranger_reading_type oldest;

   // Convert a finished pulse into a distance, push it into the channel's
   // window and return the new window average.
   function automatic logic [DIST_W-1:0] record_echo_distance(input int ch,
                                                               input int unsigned len);
      longint unsigned scaled;
      int unsigned     cm;
      int unsigned     pos;
      scaled = (longint'(len >> 1) & 64'hFFFF) * cfg_scale;
      cm     = int'(scaled >> 16) & 32'h7FFF;
      pos    = ring_pos[ch];
      if (pos >= WINDOW) pos = 0;
      ring_sum[ch]         = ring_sum[ch] - sample_ring[ch][pos] + cm;
      sample_ring[ch][pos] = cm;
      pos++;
      if (pos >= WINDOW) pos = 0;
      ring_pos[ch] = pos;
      return DIST_W'(ring_sum[ch] / WINDOW);
   endfunction

   // Advance the ranger by one accepted tick and queue its response.
   task automatic advance_ranger(input logic s, input logic [CH_W-1:0] ch,
                                 input logic [ECHO_W-1:0] e);
      ranger_reading_type r;
      logic            echo;
      int unsigned     t;
      r    = '0;
      echo = (rng_phase != PH_IDLE) && e[rng_channel];
      t    = rng_ticks;
      case (rng_phase)
         PH_IDLE: begin
            if (s) begin
               if (ch >= CHANNELS) begin
                  // bad channel: answer at once, state untouched
                  r.done   = 1'b1;
                  r.status = ST_BAD_CHANNEL;
               end else begin
                  rng_channel = ch;
                  rng_phase   = PH_TRIG_LOW;
                  t           = 1;
               end
            end
         end
         PH_TRIG_LOW: begin
            if (t >= LOW_TICKS) begin
               rng_phase = PH_TRIG_HIGH;
               t         = 1;
            end else begin
               t++;
            end
         end
         PH_TRIG_HIGH: begin
            if (t >= HIGH_TICKS) begin
               rng_phase = PH_WAIT;
               t         = 0;
            end else begin
               t++;
            end
         end
         PH_WAIT: begin
            if (echo) begin
               rng_phase = PH_MEASURE;
               t         = 1;
            end else begin
               t++;
               if (t > cfg_timeout) begin
                  r.done    = 1'b1;
                  r.status  = ST_NO_ECHO;
                  rng_phase = PH_IDLE;
                  t         = 0;
               end
            end
         end
         PH_MEASURE: begin
            if (echo) begin
               t++;
               if (t > cfg_timeout) begin
                  r.done    = 1'b1;
                  r.status  = ST_ECHO_LONG;
                  rng_phase = PH_IDLE;
                  t         = 0;
               end
            end else begin
               r.done     = 1'b1;
               r.status   = ST_OK;
               r.distance = record_echo_distance(int'(rng_channel), t);
               rng_phase  = PH_IDLE;
               t          = 0;
            end
         end
         default: begin
            rng_phase = PH_IDLE;
            t         = 0;
         end
      endcase
      rng_ticks = TICK_W'(t);
      r.trig = (rng_phase == PH_TRIG_HIGH) ? (TRIG_W'(1) << rng_channel) : '0;
      r.busy = (rng_phase != PH_IDLE);
      pending_readings.push_back(r);
   endtask

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Send one tick. Bursts of random length are separated by random gaps;
   // hold the payload until the block accepts it, then predict.
   task automatic apply_tick(input logic s, input logic [CH_W-1:0] ch,
                             input logic [ECHO_W-1:0] e);
      int gap;
      if (!steady_sender && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_valid       = 1'b1;
      req_start_req   = s;
      req_channel     = ch;
      req_echo_levels = e;
      do @(posedge clock); while (req_stall);
      advance_ranger(s, ch, e);
      ticks_sent++;
      if (burst_left > 0) burst_left--;
   endtask

   // Drop valid, wait until every expected response is back, then let the
   // pipeline settle.
   task automatic wait_quiet();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; only called with the block idle.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ECHO_TIMEOUT: cfg_timeout = data;
         CSR_SCALE_Q16:    cfg_scale   = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // One full measurement: start, then follow the ranger until it is idle
   // again. The echo of the measured channel rises echo_delay ticks into the
   // wait and stays high for pulse_len ticks; all other echo bits are noise.
   // With noisy set, start and channel toggle while busy and must be ignored.
   task automatic run_measurement(input int ch, input int echo_delay, input int pulse_len,
                                  input bit noisy);
      int               k;
      logic [ECHO_W-1:0] e;
      k = 0;
      apply_tick(1'b1, CH_W'(ch), ECHO_W'($urandom));
      while (rng_phase != PH_IDLE) begin
         e = ECHO_W'($urandom);
         if (rng_phase == PH_WAIT || rng_phase == PH_MEASURE) begin
            e[ch] = (k >= echo_delay) && (k < echo_delay + pulse_len);
            k++;
         end
         apply_tick(noisy ? 1'($urandom_range(0, 1)) : 1'b0, CH_W'($urandom), e);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: stall pattern, checker, watchdog
   // ------------------------------------------------------------------------

   // Rotate a 16-bit stall mask; pick a new one every so often. One bit is
   // always clear, so every stall ends.
   logic [15:0] stall_mask = '0;
   int          stall_run  = 0;

   always @(negedge clock) begin
      if (stall_run == 0) begin
         stall_run = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0:       stall_mask = '0;
            1:       stall_mask = 16'($urandom & $urandom);
            2:       stall_mask = 16'($urandom);
            default: stall_mask = 16'($urandom | $urandom);
         endcase
         stall_mask[3] = 1'b0;
      end
      stall_mask = {stall_mask[14:0], stall_mask[15]};
      rsp_stall  = stall_mask[0];
      stall_run--;
   end

   function automatic void compare_field(input string what, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // Compare each accepted response with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            mismatches++;
            $display("%0t: response with nothing expected", $time);
            $display("   actual trig %0h busy %0b done %0b status %0h distance %0h",
                     rsp_trigger_levels, rsp_busy_res, rsp_done_res, rsp_status,
                     rsp_distance_cm);
         end else begin
            oldest = pending_readings.pop_front();
            compare_field("trigger_levels", oldest.trig,     rsp_trigger_levels);
            compare_field("busy_res",       oldest.busy,     rsp_busy_res);
            compare_field("done_res",       oldest.done,     rsp_done_res);
            compare_field("status",         oldest.status,   rsp_status);
            compare_field("distance_cm",    oldest.distance, rsp_distance_cm);
            readings_checked++;
            if (oldest.done) finished_by_status[oldest.status]++;
         end
      end
   end

   // End the run if nothing moves on either channel for too long.
   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** ultrasonic_echo_ranger_averaged: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Power-on settings: default timeout and scale, no register writes yet.
   task automatic test_power_on_defaults();
      apply_tick(1'b0, 2'd0, 3'b000);
      apply_tick(1'b0, 2'd3, 3'b111);
      run_measurement(0, 3, 40, 1'b0);
      run_measurement(2, 0, 1, 1'b0);
      wait_quiet();
   endtask

   // Invalid channel answers at once; starts while busy are ignored.
   task automatic test_bad_channel_and_busy();
      apply_tick(1'b1, 2'd3, 3'b111);
      apply_tick(1'b1, 2'd3, 3'b000);
      run_measurement(1, 5, 20, 1'b1);
      run_measurement(3, 0, 0, 1'b0);
      run_measurement(0, 9, 12, 1'b1);
      wait_quiet();
   endtask

   // Timeout at both ends and right at a small limit; the largest scale
   // runs under the largest timeout.
   task automatic test_timeout_limits();
      write_csr(CSR_ECHO_TIMEOUT, 16'd0);
      run_measurement(0, 0, 1, 1'b0);          // shortest good pulse
      run_measurement(0, 0, 2, 1'b0);          // echo too long at once
      run_measurement(1, 1, 5, 1'b0);          // no echo start at once
      wait_quiet();
      write_csr(CSR_ECHO_TIMEOUT, 16'hFFFF);
      write_csr(CSR_SCALE_Q16, 16'hFFFF);
      run_measurement(2, 2, 60, 1'b0);         // largest timeout and scale
      wait_quiet();
      write_csr(CSR_ECHO_TIMEOUT, 16'd20);
      run_measurement(2, 0, 20, 1'b0);         // longest pulse inside the limit
      run_measurement(2, 0, 21, 1'b0);         // one tick past the limit
      run_measurement(0, 21, 3, 1'b0);         // echo starts one tick too late
      wait_quiet();
   endtask

   // Scale at both ends.
   task automatic test_scale_limits();
      write_csr(CSR_ECHO_TIMEOUT, 16'd30);
      write_csr(CSR_SCALE_Q16, 16'd0);
      run_measurement(1, 4, 20, 1'b0);
      wait_quiet();
      write_csr(CSR_SCALE_Q16, 16'hFFFF);
      run_measurement(1, 0, 29, 1'b0);
      run_measurement(1, 7, 30, 1'b0);
      wait_quiet();
   endtask

   // Wrap channel 1's window, with another channel in between to show that
   // windows stay separate. Sender runs without gaps here.
   task automatic test_window_wrap();
      steady_sender = 1'b1;
      write_csr(CSR_ECHO_TIMEOUT, 16'd1000);
      write_csr(CSR_SCALE_Q16, 16'hC000);
      for (int i = 0; i < WINDOW + 2; i++) begin
         run_measurement(1, i, 3 + 4 * i, 1'b0);
         if (i == 2) run_measurement(0, 1, 30, 1'b0);
      end
      wait_quiet();
      steady_sender = 1'b0;
   endtask

   // Random measurement sequences under changing settings. Each round starts
   // with the block drained, which also holds the sender until all
   // responses are back.
   task automatic test_random_ranging();
      int first_tick;
      int timeout_sel;
      int span;
      int ch;
      int echo_delay;
      int pulse_len;
      first_tick = ticks_sent;
      while (ticks_sent - first_tick < RANDOM_TICKS) begin
         wait_quiet();
         case ($urandom_range(0, 9))
            0:       timeout_sel = 0;
            1:       timeout_sel = 1;
            2:       timeout_sel = 65535;
            default: timeout_sel = $urandom_range(2, 60);
         endcase
         write_csr(CSR_ECHO_TIMEOUT, CSR_DATA_W'(timeout_sel));
         case ($urandom_range(0, 5))
            0:       write_csr(CSR_SCALE_Q16, 16'd0);
            1:       write_csr(CSR_SCALE_Q16, 16'hFFFF);
            2:       write_csr(CSR_SCALE_Q16, 16'd2249);
            default: write_csr(CSR_SCALE_Q16, 16'($urandom));
         endcase
         span = (timeout_sel > 60) ? 60 : timeout_sel;
         for (int m = $urandom_range(4, 10);
              m > 0 && ticks_sent - first_tick < RANDOM_TICKS; m--) begin
            // idle noise between measurements
            repeat ($urandom_range(0, 3))
               apply_tick(1'b0, CH_W'($urandom), ECHO_W'($urandom));
            ch         = ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2);
            echo_delay = $urandom_range(0, span);
            pulse_len  = $urandom_range(1, (span == 0) ? 1 : span);
            case ($urandom_range(0, 7))
               0: if (timeout_sel <= 60) echo_delay = timeout_sel + $urandom_range(1, 3);
               1: if (timeout_sel <= 60) pulse_len  = timeout_sel + $urandom_range(1, 3);
               default: ;
            endcase
            run_measurement(ch, echo_delay, pulse_len, 1'($urandom_range(0, 1)));
         end
      end
      wait_quiet();
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      // Drive every input to a known value from time zero.
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_start_req   = 1'b0;
      req_channel     = '0;
      req_echo_levels = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_ECHO_TIMEOUT;
      csr_wdata       = '0;

      // Ranger state after reset
      cfg_timeout = ECHO_TIMEOUT_RST;
      cfg_scale   = SCALE_Q16_RST;
      rng_phase   = PH_IDLE;
      rng_channel = '0;
      rng_ticks   = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         ring_pos[c] = 0;
         ring_sum[c] = 0;
         for (int w = 0; w < WINDOW; w++) sample_ring[c][w] = 0;
      end
      mismatches       = 0;
      ticks_sent       = 0;
      readings_checked = 0;
      burst_left       = 0;
      steady_sender    = 1'b0;
      for (int s = 0; s < 4; s++) finished_by_status[s] = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_defaults();
      test_bad_channel_and_busy();
      test_timeout_limits();
      test_scale_limits();
      test_window_wrap();
      test_random_ranging();

      $display("Run covered %0d sensor ticks, %0d responses checked.",
               ticks_sent, readings_checked);
      $display("Finished requests: %0d ok, %0d bad channel, %0d no echo, %0d echo too long.",
               finished_by_status[ST_OK], finished_by_status[ST_BAD_CHANNEL],
               finished_by_status[ST_NO_ECHO], finished_by_status[ST_ECHO_LONG]);
      if (mismatches == 0) begin
         $display("** ultrasonic_echo_ranger_averaged: PASSED **");
      end else begin
         $display("** ultrasonic_echo_ranger_averaged: FAILED **");
      end
      $finish;
   end

endmodule
